// File: sv/line_sensor_pd_steering_defines.svh
// ----------------------------------------------------------------------------
// Line sensor PD steering: assertion macros
// Shared property shorthands for the checker of the steering block.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PD_STEERING_DEFINES_SVH
`define LINE_SENSOR_PD_STEERING_DEFINES_SVH

// Same-cycle implication, muted while reset is low.
`define LSPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering check failed");

// Next-cycle implication, muted while reset is low.
`define LSPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering check failed");

`endif

// File: sv/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg
// Widths, constants, codes and control types of the line sensor PD steering.
// ----------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

  localparam int SENSOR_N   = 6;
  localparam int SPEED_W    = 15;
  localparam int ERR_W      = 12;
  localparam int SUM_W      = 13;
  localparam int MAG_W      = 12;
  localparam int CNT_W      = 3;
  localparam int KP_W       = 16;
  localparam int KD_W       = 20;
  localparam int PD_W       = 34;
  localparam int Q_W        = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Two quotient bits per division cycle.
  localparam int DIV_STEPS  = MAG_W / 2;
  localparam int DIV_CNT_W  = 3;

  localparam logic [KP_W-1:0]    RST_PROP_GAIN  = 16'd256;
  localparam logic [KD_W-1:0]    RST_DERIV_GAIN = 20'd4864;
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED = 15'd3840;
  localparam logic [SPEED_W-1:0] SPEED_MAX      = 15'h7FFF;
  localparam logic [PD_W-1:0]    ROUND_HALF     = 34'd128;

  // Lateral weight of each sensor, Q.8 (5.4, 4.4, 2.8 mirrored).
  localparam logic signed [SUM_W-1:0] WEIGHT [SENSOR_N] = '{
    13'sd1382, 13'sd1126, 13'sd717, -13'sd717, -13'sd1126, -13'sd1382
  };

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_MUL_P = 7'b0000100,
    S_MUL_D = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_LOAD  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic mul_p;
    logic mul_d;
    logic round;
    logic apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_seen;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: sv/lsps_if.sv
// ----------------------------------------------------------------------------
// lsps_in_if / lsps_out_if
// Valid/ready channels for sensor beats and steering result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsps_in_if;
  logic                                valid;
  logic                                ready;
  logic [lsps_pkg::SENSOR_N-1:0]       sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lsps_out_if;
  logic                                valid;
  logic                                ready;
  logic [lsps_pkg::SPEED_W-1:0]        left_target;
  logic [lsps_pkg::SPEED_W-1:0]        right_target;
  logic                                line_seen;
  logic signed [lsps_pkg::ERR_W-1:0]   lateral_error;

  modport source (output valid, output left_target, output right_target,
                  output line_seen, output lateral_error, input ready);
  modport sink   (input valid, input left_target, input right_target,
                  input line_seen, input lateral_error, output ready);
endinterface

`default_nettype wire

// File: sv/lsps_datapath.sv
// ----------------------------------------------------------------------------
// lsps_datapath
// Weight sum, serial divider, PD multiply-accumulate, rounding, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lsps_pkg::cmd_t                       cmd,
  output lsps_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [lsps_pkg::SENSOR_N-1:0]        in_sensor_bits,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [lsps_pkg::SPEED_W-1:0]         out_left_target,
  output logic [lsps_pkg::SPEED_W-1:0]         out_right_target,
  output logic                                 out_line_seen,
  output logic signed [lsps_pkg::ERR_W-1:0]    out_lateral_error
);

  logic [lsps_pkg::KP_W-1:0]          kp_r;
  logic [lsps_pkg::KD_W-1:0]          kd_r;
  logic [lsps_pkg::SPEED_W-1:0]       base_r;

  logic [lsps_pkg::CNT_W-1:0]         cnt_r;
  logic [lsps_pkg::CNT_W-1:0]         rem_r;
  logic [lsps_pkg::MAG_W-1:0]         quo_r;
  logic                               neg_r;
  logic                               center_r;
  logic                               seen_r;
  logic [lsps_pkg::DIV_CNT_W-1:0]     div_cnt_r;
  logic signed [lsps_pkg::ERR_W-1:0]  err_r;
  logic signed [lsps_pkg::ERR_W-1:0]  last_err_r;
  logic signed [lsps_pkg::PD_W-1:0]   acc_r;
  logic [lsps_pkg::Q_W-1:0]           q_r;
  logic                               pd_neg_r;
  logic                               pd_nz_r;
  logic [lsps_pkg::SPEED_W-1:0]       left_r;
  logic [lsps_pkg::SPEED_W-1:0]       right_r;
  logic                               out_valid_r;
  logic [lsps_pkg::SPEED_W-1:0]       out_left_r;
  logic [lsps_pkg::SPEED_W-1:0]       out_right_r;
  logic                               out_seen_r;
  logic signed [lsps_pkg::ERR_W-1:0]  out_err_r;

  logic signed [lsps_pkg::SUM_W-1:0]  sum_in;
  logic [lsps_pkg::CNT_W-1:0]         cnt_in;
  logic                               center_in;
  logic [lsps_pkg::MAG_W-1:0]         mag_in;

  logic [lsps_pkg::CNT_W:0]           rem_a4;
  logic [lsps_pkg::CNT_W:0]           rem_b4;
  logic                               ge_a;
  logic                               ge_b;
  logic [lsps_pkg::CNT_W-1:0]         rem_a;
  logic [lsps_pkg::CNT_W-1:0]         rem_nxt;
  logic [lsps_pkg::MAG_W-1:0]         quo_a;
  logic [lsps_pkg::MAG_W-1:0]         quo_nxt;

  logic signed [lsps_pkg::ERR_W-1:0]  err_div;
  logic signed [lsps_pkg::SUM_W-1:0]  err_diff;
  logic signed [lsps_pkg::PD_W-1:0]   prod_p;
  logic signed [lsps_pkg::PD_W-1:0]   prod_d;
  logic [lsps_pkg::PD_W-1:0]          acc_mag;
  logic [lsps_pkg::PD_W-1:0]          acc_rnd;
  logic [lsps_pkg::Q_W:0]             up_sum;
  logic [lsps_pkg::SPEED_W-1:0]       up_sat;
  logic [lsps_pkg::SPEED_W-1:0]       dn_sat;

  // Weight sum and lit count of the incoming beat.
  always_comb begin
    sum_in = '0;
    cnt_in = '0;
    for (int i = 0; i < lsps_pkg::SENSOR_N; i++) begin
      if (in_sensor_bits[i]) begin
        sum_in = sum_in + lsps_pkg::WEIGHT[i];
        cnt_in = cnt_in + lsps_pkg::CNT_W'(1);
      end
    end
    center_in = in_sensor_bits[2] && in_sensor_bits[3];
    mag_in    = sum_in[lsps_pkg::SUM_W-1] ? lsps_pkg::MAG_W'(-sum_in)
                                           : lsps_pkg::MAG_W'(sum_in);
  end

  // Two restoring divide steps per cycle; quotient shifts into quo_r.
  always_comb begin
    rem_a4  = {rem_r, quo_r[lsps_pkg::MAG_W-1]};
    ge_a    = rem_a4 >= {1'b0, cnt_r};
    rem_a   = ge_a ? lsps_pkg::CNT_W'(rem_a4 - {1'b0, cnt_r})
                   : rem_a4[lsps_pkg::CNT_W-1:0];
    quo_a   = {quo_r[lsps_pkg::MAG_W-2:0], ge_a};
    rem_b4  = {rem_a, quo_a[lsps_pkg::MAG_W-1]};
    ge_b    = rem_b4 >= {1'b0, cnt_r};
    rem_nxt = ge_b ? lsps_pkg::CNT_W'(rem_b4 - {1'b0, cnt_r})
                   : rem_b4[lsps_pkg::CNT_W-1:0];
    quo_nxt = {quo_a[lsps_pkg::MAG_W-2:0], ge_b};
  end

  // PD products, rounding and saturated targets.
  always_comb begin
    err_div  = neg_r ? -quo_r : quo_r;
    err_diff = lsps_pkg::SUM_W'(err_r) - lsps_pkg::SUM_W'(last_err_r);
    prod_p   = lsps_pkg::PD_W'(err_div) * lsps_pkg::PD_W'($signed({1'b0, kp_r}));
    prod_d   = lsps_pkg::PD_W'(err_diff) * lsps_pkg::PD_W'($signed({1'b0, kd_r}));
    acc_mag  = acc_r[lsps_pkg::PD_W-1] ? lsps_pkg::PD_W'(-acc_r)
                                       : lsps_pkg::PD_W'(acc_r);
    acc_rnd  = acc_mag + lsps_pkg::ROUND_HALF;
    up_sum   = {{(lsps_pkg::Q_W + 1 - lsps_pkg::SPEED_W){1'b0}}, base_r}
             + {1'b0, q_r};
    up_sat   = (up_sum > {{(lsps_pkg::Q_W + 1 - lsps_pkg::SPEED_W){1'b0}},
                          lsps_pkg::SPEED_MAX})
             ? lsps_pkg::SPEED_MAX : up_sum[lsps_pkg::SPEED_W-1:0];
    dn_sat   = (q_r > {{(lsps_pkg::Q_W - lsps_pkg::SPEED_W){1'b0}}, base_r})
             ? '0 : base_r - q_r[lsps_pkg::SPEED_W-1:0];
  end

  always_comb begin
    status.in_seen  = |in_sensor_bits;
    status.div_last = div_cnt_r == lsps_pkg::DIV_CNT_W'(lsps_pkg::DIV_STEPS - 1);
    status.out_free = !out_valid_r || out_ready;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= lsps_pkg::RST_PROP_GAIN;
      kd_r        <= lsps_pkg::RST_DERIV_GAIN;
      base_r      <= lsps_pkg::RST_BASE_SPEED;
      last_err_r  <= '0;
      left_r      <= lsps_pkg::RST_BASE_SPEED;
      right_r     <= lsps_pkg::RST_BASE_SPEED;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lsps_pkg::CFG_PROP_GAIN:  kp_r   <= cfg_wdata[lsps_pkg::KP_W-1:0];
          lsps_pkg::CFG_DERIV_GAIN: kd_r   <= cfg_wdata[lsps_pkg::KD_W-1:0];
          lsps_pkg::CFG_BASE_SPEED: base_r <= cfg_wdata[lsps_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + lsps_pkg::DIV_CNT_W'(1);
      end
      if (cmd.mul_d) begin
        last_err_r <= err_r;
      end
      if (cmd.apply) begin
        if (pd_nz_r) begin
          left_r  <= pd_neg_r ? up_sat : dn_sat;
          right_r <= pd_neg_r ? dn_sat : up_sat;
        end else if (center_r) begin
          left_r  <= base_r;
          right_r <= base_r;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt_r    <= cnt_in;
      rem_r    <= '0;
      quo_r    <= center_in ? '0 : mag_in;
      neg_r    <= sum_in[lsps_pkg::SUM_W-1] && !center_in;
      center_r <= center_in;
      seen_r   <= |in_sensor_bits;
      err_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.mul_p) begin
      err_r <= err_div;
      acc_r <= prod_p;
    end
    if (cmd.mul_d) begin
      acc_r <= acc_r + prod_d;
    end
    if (cmd.round) begin
      q_r      <= acc_rnd[lsps_pkg::PD_W-1:lsps_pkg::PD_W-lsps_pkg::Q_W];
      pd_neg_r <= acc_r[lsps_pkg::PD_W-1];
      pd_nz_r  <= acc_r != '0;
    end
    if (cmd.load_out) begin
      out_left_r  <= left_r;
      out_right_r <= right_r;
      out_seen_r  <= seen_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_target   = out_left_r;
  assign out_right_target  = out_right_r;
  assign out_line_seen     = out_seen_r;
  assign out_lateral_error = out_err_r;

endmodule

`default_nettype wire

// File: sv/lsps_ctrl.sv
// ----------------------------------------------------------------------------
// lsps_ctrl
// Sequencer: accept, divide, multiply, round, apply, load the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsps_pkg::status_t  status,
  output lsps_pkg::cmd_t     cmd
);

  lsps_pkg::state_t state_r;
  lsps_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lsps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          // A dark beat skips the arithmetic.
          state_nxt = status.in_seen ? lsps_pkg::S_DIV : lsps_pkg::S_LOAD;
        end
      end
      lsps_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = lsps_pkg::S_MUL_P;
        end
      end
      lsps_pkg::S_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = lsps_pkg::S_MUL_D;
      end
      lsps_pkg::S_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = lsps_pkg::S_ROUND;
      end
      lsps_pkg::S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = lsps_pkg::S_APPLY;
      end
      lsps_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = lsps_pkg::S_LOAD;
      end
      lsps_pkg::S_LOAD: begin
        // Hold until the output register is free.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = lsps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lsps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/line_sensor_pd_steering.sv
// ----------------------------------------------------------------------------
// line_sensor_pd_steering
// Six-sensor line offset with PD steering of two wheel speed targets.
//
//   channel   dir  beat contents
//   in_ch     in   sensor_bits[5:0]
//   out_ch    out  left_target, right_target, line_seen, lateral_error
//   cfg_*     in   prop_gain (0), deriv_gain_rate (1), base_speed (2)
//
// A beat with a lit sensor goes from accept through the divider (two quotient
// bits per divider cycle, for the divide of the weight sum by the lit count),
// a multiply-accumulate of the proportional product, then of the derivative
// product, a round, an apply and the result load. A dark beat goes from
// accept straight to the result load.
// in_ch.ready is high only while the sequencer is idle; a result waiting
// on out_ch does not block the next accept, only the next load.
// Reset (rst_n low, synchronous) restores register defaults and targets.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_pd_steering (
  input  logic                                clk,
  input  logic                                rst_n,
  lsps_in_if.sink                             in_ch,
  lsps_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lsps_pkg::cmd_t    cmd;
  lsps_pkg::status_t status;
  logic              in_ready;

  // Sequencer: one beat in flight, result parked in the output register.
  lsps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, held state, config registers and output register.
  lsps_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sensor_bits    (in_ch.sensor_bits),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_left_target   (out_ch.left_target),
    .out_right_target  (out_ch.right_target),
    .out_line_seen     (out_ch.line_seen),
    .out_lateral_error (out_ch.lateral_error)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// File: sv/lsps_checker.sv
// ----------------------------------------------------------------------------
// lsps_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_pd_steering_defines.svh"

module lsps_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [lsps_pkg::SPEED_W-1:0]        left_target,
  input  logic [lsps_pkg::SPEED_W-1:0]        right_target,
  input  logic                                line_seen,
  input  logic signed [lsps_pkg::ERR_W-1:0]   lateral_error
);

  // A stalled result beat holds.
  `LSPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({left_target, right_target, line_seen, lateral_error}))

  // A dark beat reports no offset.
  `LSPS_ASSERT_IMP(a_dark_zero, clk, rst_n, out_valid && !line_seen, lateral_error == '0)

  // One beat at a time: busy right after an accept.
  `LSPS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind line_sensor_pd_steering lsps_checker u_lsps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .left_target   (out_ch.left_target),
  .right_target  (out_ch.right_target),
  .line_seen     (out_ch.line_seen),
  .lateral_error (out_ch.lateral_error)
);

`default_nettype wire
